>>> hw/rtl/ufq_pkg.sv
// Package for the unique-entry FIFO queue.
// Holds the request, status and sequencer types; imported by every module but ufq_ram; no dependencies.

package ufq_pkg;

    // Width of a stored value.
    localparam int unsigned VALUE_W = 32;

    // Value returned on every result other than a successful dequeue.
    localparam logic [VALUE_W-1:0] NO_VALUE = '1;

    // Result status codes.
    typedef enum logic [2:0] {
        STAT_DEQUEUED  = 3'd0,
        STAT_EMPTY     = 3'd1,
        STAT_APPENDED  = 3'd2,
        STAT_DUPLICATE = 3'd3,
        STAT_FULL      = 3'd4
    } t_status;

    // Request as classified by the front end.
    typedef struct packed {
        logic               is_deq;
        logic [VALUE_W-1:0] value;
    } t_cmd;

    // Back-end sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DEQ,
        ST_SCAN,
        ST_RESULT
    } t_state;

endpackage

>>> hw/rtl/ufq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.

module ufq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hw/rtl/ufq_front.sv
// Front end of the unique-entry FIFO queue: accepts requests, classifies them
// and holds them in a two-entry queue for the back end. Depends on ufq_pkg.

module ufq_front
    import ufq_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_op,
    input  logic signed [VALUE_W-1:0] i_value,
    output logic                      o_cmd_valid,
    output t_cmd                      o_cmd,
    input  logic                      i_cmd_pop
);

    t_cmd       r_buf [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_fill;
    logic       n_wr_ptr;
    logic       n_rd_ptr;
    logic [1:0] n_fill;
    logic       push;
    logic       pop;
    t_cmd       cmd_in;

    // Classify the incoming request.
    always_comb begin
        cmd_in.is_deq = i_op;
        cmd_in.value  = i_value;
    end

    assign o_ready     = (r_fill != 2'd2);
    assign push        = i_valid && o_ready;
    assign o_cmd_valid = (r_fill != 2'd0);
    assign pop         = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_buf[r_rd_ptr];

    // Pointer and fill updates.
    always_comb begin
        n_wr_ptr = push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop ? ~r_rd_ptr : r_rd_ptr;
        n_fill   = r_fill;
        if (push && !pop) begin
            n_fill = r_fill + 2'd1;
        end else if (pop && !push) begin
            n_fill = r_fill - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    // Queue storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wr_ptr] <= cmd_in;
        end
    end

endmodule

>>> hw/rtl/ufq_back.sv
// Back end of the unique-entry FIFO queue: carries out one request at a time,
// scanning the entry RAM for duplicates, and owns the result register.
// Depends on ufq_pkg and ufq_ram.

module ufq_back
    import ufq_pkg::*;
#(
    parameter int unsigned DEPTH = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cmd_valid,
    input  t_cmd                      i_cmd,
    output logic                      o_cmd_pop,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [2:0]                o_status,
    output logic signed [VALUE_W-1:0] o_popped_value
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_state             r_state, n_state;
    logic [AW-1:0]      r_head, n_head;
    logic [AW-1:0]      r_tail, n_tail;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_idx, n_idx;
    logic [AW-1:0]      r_slot, n_slot;
    logic               r_pend, n_pend;
    logic [VALUE_W-1:0] r_val, n_val;
    t_status            r_res_status, n_res_status;
    logic [VALUE_W-1:0] r_res_value, n_res_value;
    logic               r_o_valid, n_o_valid;
    t_status            r_o_status, n_o_status;
    logic [VALUE_W-1:0] r_o_value, n_o_value;

    logic               ram_wr_en;
    logic [AW-1:0]      ram_wr_addr;
    logic [VALUE_W-1:0] ram_wr_data;
    logic               ram_rd_en;
    logic [AW-1:0]      ram_rd_addr;
    logic [VALUE_W-1:0] ram_rd_data;
    logic               out_free;

    // Entry storage.
    ufq_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // Advance a slot index round the circular buffer.
    function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] slot);
        logic [AW-1:0] res;
        if (slot == AW'(DEPTH - 1)) begin
            res = '0;
        end else begin
            res = slot + 1'b1;
        end
        return res;
    endfunction

    assign out_free = !r_o_valid || i_ready;

    // Sequencer: next state, RAM control and result formation.
    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_idx        = r_idx;
        n_slot       = r_slot;
        n_pend       = r_pend;
        n_val        = r_val;
        n_res_status = r_res_status;
        n_res_value  = r_res_value;
        n_o_valid    = r_o_valid && !i_ready;
        n_o_status   = r_o_status;
        n_o_value    = r_o_value;
        o_cmd_pop    = 1'b0;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = r_tail;
        ram_wr_data  = r_val;
        ram_rd_en    = 1'b0;
        ram_rd_addr  = r_slot;

        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_val     = i_cmd.value;
                    if (i_cmd.is_deq) begin
                        if (r_count == '0) begin
                            n_res_status = STAT_EMPTY;
                            n_res_value  = NO_VALUE;
                            n_state      = ST_RESULT;
                        end else begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = r_head;
                            n_state     = ST_DEQ;
                        end
                    end else begin
                        n_idx   = '0;
                        n_slot  = r_head;
                        n_pend  = 1'b0;
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_DEQ: begin
                // Read data for the head entry is now available.
                n_res_status = STAT_DEQUEUED;
                n_res_value  = ram_rd_data;
                n_head       = next_slot(r_head);
                n_count      = r_count - 1'b1;
                n_state      = ST_RESULT;
            end
            ST_SCAN: begin
                // One entry read per cycle; compare the previous read's data.
                if (r_pend && (ram_rd_data == r_val)) begin
                    n_pend       = 1'b0;
                    n_res_status = STAT_DUPLICATE;
                    n_res_value  = NO_VALUE;
                    n_state      = ST_RESULT;
                end else if (r_idx != r_count) begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = r_slot;
                    n_slot      = next_slot(r_slot);
                    n_idx       = r_idx + 1'b1;
                    n_pend      = 1'b1;
                end else if (r_pend) begin
                    n_pend = 1'b0;
                end else begin
                    n_res_value = NO_VALUE;
                    if (r_count == CW'(DEPTH)) begin
                        n_res_status = STAT_FULL;
                    end else begin
                        ram_wr_en    = 1'b1;
                        n_tail       = next_slot(r_tail);
                        n_count      = r_count + 1'b1;
                        n_res_status = STAT_APPENDED;
                    end
                    n_state = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_res_status;
                    n_o_value  = r_res_value;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_idx     <= '0;
            r_slot    <= '0;
            r_pend    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_count   <= n_count;
            r_idx     <= n_idx;
            r_slot    <= n_slot;
            r_pend    <= n_pend;
            r_o_valid <= n_o_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_val        <= n_val;
        r_res_status <= n_res_status;
        r_res_value  <= n_res_value;
        r_o_status   <= n_o_status;
        r_o_value    <= n_o_value;
    end

    assign o_valid        = r_o_valid;
    assign o_status       = r_o_status;
    assign o_popped_value = r_o_value;

endmodule

>>> hw/rtl/unique_entry_fifo_queue.sv
// Top level of the unique-entry FIFO queue.
// Depends on ufq_pkg, ufq_front, ufq_back and ufq_ram.
//
// A FIFO of 32-bit signed values that never holds the same value twice.
// Input channel (i_valid/o_ready) carries i_op (0 enqueue, 1 dequeue) and
// i_value. Output channel (o_valid/i_ready) returns exactly one result per
// request: o_status (dequeued, empty, appended, duplicate, full) and
// o_popped_value, which is -1 except on a successful dequeue.
// A two-entry request queue in front lets requests be taken while the back
// end works or while a result waits in the output register; an accepted
// request is registered in that queue before it reaches the back end.
// A dequeue passes from the idle state through a head read (ST_DEQ) to the
// result state; an empty dequeue goes straight to the result state. An enqueue
// scans the stored entries for a duplicate, reading one entry per cycle through
// the single RAM read port, then appends the value or reports full or duplicate.
// The back end handles one request at a time, so it takes no new request until
// the result of the last one is in the output register.
// Reset empties the queue at once; the entry RAM is not cleared.
// When the receiver stalls, the result holds in the output register, the
// back end finishes at most one more request and the request queue fills,
// after which o_ready falls.

module unique_entry_fifo_queue
    import ufq_pkg::*;
#(
    parameter int unsigned DEPTH = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_op,
    input  logic signed [VALUE_W-1:0] i_value,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [2:0]                o_status,
    output logic signed [VALUE_W-1:0] o_popped_value
);

    logic cmd_valid;
    t_cmd cmd;
    logic cmd_pop;

    // Request intake and classification.
    ufq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_op        (i_op),
        .i_value     (i_value),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // Execution and result delivery.
    ufq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (cmd_valid),
        .i_cmd          (cmd),
        .o_cmd_pop      (cmd_pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_popped_value (o_popped_value)
    );

endmodule

>>> verif/unique_entry_fifo_queue_tb.sv
// Self-checking testbench for the unique-entry FIFO queue.
// Depends on ufq_pkg and unique_entry_fifo_queue; a shadow queue predicts each result.

module unique_entry_fifo_queue_tb;
    import ufq_pkg::*;

    localparam int unsigned DEPTH           = 64;
    localparam int unsigned CYCLE_LIMIT     = 600_000;
    localparam int unsigned RANDOM_REQUESTS = 450;
    localparam int unsigned STALL_PERCENT   = 11;
    localparam logic        OP_ENQUEUE      = 1'b0;
    localparam logic        OP_DEQUEUE      = 1'b1;

    // One predicted result.
    typedef struct {
        t_status                   status;
        logic signed [VALUE_W-1:0] popped;
    } t_outcome;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_ready;
    logic                      i_op;
    logic signed [VALUE_W-1:0] i_value;
    logic                      o_valid;
    logic                      i_ready = 1'b0;
    logic [2:0]                o_status;
    logic signed [VALUE_W-1:0] o_popped_value;

    // Shadow copy of the queue contents, oldest first, and results still owed.
    logic signed [VALUE_W-1:0] stored_values[$];
    t_outcome                  pending_results[$];
    int unsigned               error_count = 0;
    int unsigned               cycle_count = 0;
    logic                      quiet = 1'b0;

    unique_entry_fifo_queue #(
        .DEPTH(DEPTH)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_op          (i_op),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_popped_value(o_popped_value)
    );

    always #2 i_clk = ~i_clk;

    // Apply one accepted request to the shadow queue and record the result it owes.
    function automatic void shadow_queue_step(logic op, logic signed [VALUE_W-1:0] val);
        t_outcome res;
        bit       found;
        res.popped = NO_VALUE;
        found      = 1'b0;
        if (op == OP_DEQUEUE) begin
            if (stored_values.size() == 0) begin
                res.status = STAT_EMPTY;
            end else begin
                res.popped = stored_values.pop_front();
                res.status = STAT_DEQUEUED;
            end
        end else begin
            foreach (stored_values[i]) begin
                if (stored_values[i] == val) found = 1'b1;
            end
            // A value already held wins over the full check.
            if (found) begin
                res.status = STAT_DUPLICATE;
            end else if (stored_values.size() >= DEPTH) begin
                res.status = STAT_FULL;
            end else begin
                stored_values.push_back(val);
                res.status = STAT_APPENDED;
            end
        end
        pending_results.push_back(res);
    endfunction

    // Present one request, idling at random first, and hold it until it is taken.
    task automatic send_request(input logic op, input logic signed [VALUE_W-1:0] val);
        while (!quiet && $urandom_range(99) < STALL_PERCENT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op    <= op;
        i_value <= val;
        do @(posedge i_clk); while (!o_ready);
        shadow_queue_step(op, val);
    endtask

    // Stop sending and wait until every owed result has come back.
    task automatic wait_for_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic note_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        error_count++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    endtask

    // Receiver: stalls at random except during the quiet stretch.
    always @(posedge i_clk) begin
        i_ready <= quiet || ($urandom_range(99) >= STALL_PERCENT);
    end

    // Compare each result taken with the oldest prediction.
    always @(posedge i_clk) begin : result_check
        t_outcome want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t: result with no request outstanding, status %0d, value %0h",
                         $time, o_status, o_popped_value);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) begin
                    note_mismatch("status", 32'(want.status), 32'(o_status));
                end
                if (o_popped_value !== want.popped) begin
                    note_mismatch("popped value", want.popped, o_popped_value);
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still owed", $time, pending_results.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Dequeues from an empty queue change nothing.
    task automatic test_empty_dequeue();
        send_request(OP_DEQUEUE, $urandom);
        send_request(OP_DEQUEUE, $urandom);
    endtask

    // Extreme values, -1 stored as an ordinary value, duplicates, then drain past empty.
    task automatic test_field_extremes();
        send_request(OP_ENQUEUE, 32'sh8000_0000);
        send_request(OP_ENQUEUE, 32'sh7FFF_FFFF);
        send_request(OP_ENQUEUE, -32'sd1);
        send_request(OP_ENQUEUE, 32'sd0);
        send_request(OP_ENQUEUE, 32'sh5555_5555);
        send_request(OP_ENQUEUE, 32'shAAAA_AAAA);
        send_request(OP_ENQUEUE, -32'sd1);
        send_request(OP_ENQUEUE, 32'sh8000_0000);
        repeat (7) send_request(OP_DEQUEUE, $urandom);
    endtask

    // Fill to capacity, then a new value is dropped while a held one is a duplicate.
    task automatic test_full_boundary();
        while (stored_values.size() < DEPTH) send_request(OP_ENQUEUE, $urandom);
        send_request(OP_ENQUEUE, $urandom);
        send_request(OP_ENQUEUE, stored_values[$urandom_range(0, DEPTH - 1)]);
        send_request(OP_DEQUEUE, $urandom);
        send_request(OP_ENQUEUE, $urandom);
        send_request(OP_ENQUEUE, $urandom);
        while (stored_values.size() > 0) send_request(OP_DEQUEUE, $urandom);
        send_request(OP_DEQUEUE, $urandom);
    endtask

    // Bursts that lean towards filling, towards draining or neither, with values drawn so
    // that duplicates are common; the sender pauses for all results now and then.
    task automatic test_random_traffic();
        int unsigned               sent;
        int unsigned               burst;
        int unsigned               lean;
        int unsigned               pick;
        logic                      op;
        logic signed [VALUE_W-1:0] val;
        sent = 0;
        while (sent < RANDOM_REQUESTS) begin
            pick  = $urandom_range(2);
            lean  = (pick == 0) ? 75 : (pick == 1) ? 50 : 30;
            burst = $urandom_range(20, 60);
            quiet <= (sent >= 200 && sent < 320);
            repeat (burst) begin
                op   = ($urandom_range(99) < lean) ? OP_ENQUEUE : OP_DEQUEUE;
                pick = $urandom_range(99);
                if (pick < 45) begin
                    val = $urandom_range(23) - 12;
                end else if (pick < 65 && stored_values.size() > 0) begin
                    val = stored_values[$urandom_range(0, stored_values.size() - 1)];
                end else begin
                    val = $urandom;
                end
                send_request(op, val);
                sent++;
                if (sent % 150 == 0) wait_for_results();
            end
        end
        quiet <= 1'b0;
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_op    <= OP_ENQUEUE;
        i_value <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_dequeue();
        test_field_extremes();
        wait_for_results();
        quiet <= 1'b1;
        test_full_boundary();
        quiet <= 1'b0;
        test_full_boundary();
        test_random_traffic();

        // Let the last results drain, then allow for a full scan more.
        wait_for_results();
        repeat (DEPTH + 10) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
